// ===== src/fmhp_pkg.sv =====
`default_nettype none
package fmhp_pkg;

  localparam int unsigned RateW    = 20;
  localparam int unsigned SamplesW = 36;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned LenW     = 24;
  localparam int unsigned KindW    = 7;
  localparam int unsigned DivCntW  = 6;

  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(SamplesW - 1);

  localparam logic [KindW-1:0] KindStreamInfo = '0;
  localparam logic [LenW-1:0]  InfoMinLen     = LenW'(18);

  // byte offsets of the stream info fields inside the block body
  localparam logic [LenW-1:0] OffRateHi   = LenW'(10);
  localparam logic [LenW-1:0] OffRateMid  = LenW'(11);
  localparam logic [LenW-1:0] OffRateLo   = LenW'(12);
  localparam logic [LenW-1:0] OffSampHi   = LenW'(13);
  localparam logic [LenW-1:0] OffSamp3    = LenW'(14);
  localparam logic [LenW-1:0] OffSamp2    = LenW'(15);
  localparam logic [LenW-1:0] OffSamp1    = LenW'(16);
  localparam logic [LenW-1:0] OffSamp0    = LenW'(17);

  localparam logic [LenW-1:0] MagicLastIdx  = LenW'(3);
  localparam logic [LenW-1:0] HeaderLastIdx = LenW'(3);

  typedef enum logic [1:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_BODY,
    PH_IGNORE
  } phase_e;

  typedef enum logic [1:0] {
    CTRL_RUN,
    CTRL_DIV,
    CTRL_HOLD
  } ctrl_state_e;

  typedef struct packed {
    logic take_byte;
    logic start;
    logic div_step;
    logic load_out;
  } cmd_t;

  // "fLaC"
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h66;
      2'd1:    b = 8'h4C;
      2'd2:    b = 8'h61;
      default: b = 8'h43;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== src/fmhp_if.sv =====
`default_nettype none
interface fmhp_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fmhp_res_if;
  logic        valid;
  logic        ready;
  logic        is_flac;
  logic        info_found;
  logic [3:0]  channel_count;
  logic [19:0] sample_rate;
  logic [35:0] total_samples;
  logic [35:0] play_seconds;
  logic        rate_zero;

  modport source (output valid, output is_flac, output info_found, output channel_count,
                  output sample_rate, output total_samples, output play_seconds,
                  output rate_zero, input ready);
  modport sink   (input valid, input is_flac, input info_found, input channel_count,
                  input sample_rate, input total_samples, input play_seconds,
                  input rate_zero, output ready);
endinterface
`default_nettype wire

// ===== src/flac_metadata_header_parser_unit.sv =====
// flac metadata header parser
//
// req_i carries the bytes of one file buffer, one request per byte, with
// last_byte marking the final byte of the buffer. the parser checks the
// "fLaC" magic, walks the metadata block headers and captures the first
// fields of every complete stream info block (the last complete one wins).
//
// res_o carries one result per buffer: magic flag, stream info found,
// channels, sample rate, total samples, playtime in seconds and a zero
// rate flag.
//
// throughput: one byte per cycle while a buffer streams in. the last byte
// starts a restoring divider (one quotient bit per cycle), and the parser
// takes no new bytes until the division ends and its result is loaded.
// the result sits in an output register; new bytes are taken while it
// waits, but a finished result is not overwritten: if the receiver still
// stalls when the next division ends, the parser holds off the next bytes.
//
// reset clears the parser to the magic check phase with nothing pending;
// after each result the parser returns to that same state on its own.
`default_nettype none
module flac_metadata_header_parser_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fmhp_req_if.sink  req_i,
  fmhp_res_if.source res_o
);

  fmhp_pkg::cmd_t cmd;

  // sequencing: byte intake, divide steps, result handoff
  fmhp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_last_i   (req_i.last_byte),
    .in_ready_o  (req_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd)
  );

  // block walker, stream info capture, divider and result register
  fmhp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .data_byte_i     (req_i.data_byte),
    .last_byte_i     (req_i.last_byte),
    .is_flac_o       (res_o.is_flac),
    .info_found_o    (res_o.info_found),
    .channel_count_o (res_o.channel_count),
    .sample_rate_o   (res_o.sample_rate),
    .total_samples_o (res_o.total_samples),
    .play_seconds_o  (res_o.play_seconds),
    .rate_zero_o     (res_o.rate_zero)
  );

endmodule
`default_nettype wire

// ===== src/fmhp_ctrl.sv =====
`default_nettype none
module fmhp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output fmhp_pkg::cmd_t     cmd_o
);

  fmhp_pkg::ctrl_state_e           state_q, state_d;
  logic [fmhp_pkg::DivCntW-1:0]    cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fmhp_pkg::CTRL_RUN: begin
        if (in_valid_i && in_last_i) state_d = fmhp_pkg::CTRL_DIV;
      end
      fmhp_pkg::CTRL_DIV: begin
        if (cnt_q == fmhp_pkg::DivLastStep) state_d = fmhp_pkg::CTRL_HOLD;
      end
      fmhp_pkg::CTRL_HOLD: begin
        if (out_free) state_d = fmhp_pkg::CTRL_RUN;
      end
      default: state_d = fmhp_pkg::CTRL_RUN;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cnt_d       = '0;
    unique case (state_q)
      fmhp_pkg::CTRL_RUN: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = in_valid_i;
        cmd_o.start     = in_valid_i && in_last_i;
      end
      fmhp_pkg::CTRL_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      fmhp_pkg::CTRL_HOLD: begin
        cmd_o.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fmhp_pkg::CTRL_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_last_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_last_i) |=> (state_q == fmhp_pkg::CTRL_DIV && cnt_q == '0))
    else $error("last byte did not start the division");

  a_div_ends_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fmhp_pkg::CTRL_DIV && cnt_q == fmhp_pkg::DivLastStep)
      |=> state_q == fmhp_pkg::CTRL_HOLD)
    else $error("division did not end after its last step");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> (out_valid_q && state_q == fmhp_pkg::CTRL_RUN))
    else $error("result load did not raise valid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

// ===== src/fmhp_datapath.sv =====
`default_nettype none
module fmhp_datapath (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire fmhp_pkg::cmd_t cmd_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             is_flac_o,
  output logic             info_found_o,
  output logic [3:0]       channel_count_o,
  output logic [19:0]      sample_rate_o,
  output logic [35:0]      total_samples_o,
  output logic [35:0]      play_seconds_o,
  output logic             rate_zero_o
);

  localparam int unsigned RW = fmhp_pkg::RateW;
  localparam int unsigned SW = fmhp_pkg::SamplesW;
  localparam int unsigned CW = fmhp_pkg::ChanW;
  localparam int unsigned LW = fmhp_pkg::LenW;
  localparam int unsigned KW = fmhp_pkg::KindW;

  // parser state
  fmhp_pkg::phase_e phase_q, phase_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] len_q, len_d;
  logic [KW-1:0] kind_q, kind_d;
  logic          fin_q, fin_d;
  logic          magic_q, magic_d;
  logic [RW-1:0] p_rate_q, p_rate_d;
  logic [SW-1:0] p_samp_q, p_samp_d;
  logic [CW-1:0] p_chan_q, p_chan_d;
  logic          c_valid_q, c_valid_d;
  logic [RW-1:0] c_rate_q, c_rate_d;
  logic [SW-1:0] c_samp_q, c_samp_d;
  logic [CW-1:0] c_chan_q, c_chan_d;

  logic          info;
  logic [LW:0]   next_idx;
  logic [LW-1:0] hdr_len;

  // result snapshot and divider
  logic          s_magic_q, s_found_q;
  logic [3:0]    s_chan_q;
  logic [RW-1:0] s_rate_q;
  logic [SW-1:0] s_samp_q;
  logic [RW:0]   rem_q;
  logic [SW-1:0] quo_q;
  logic [RW:0]   shifted;
  logic [RW:0]   diff;
  logic          s_rz;

  assign info     = (kind_q == fmhp_pkg::KindStreamInfo) && (len_q >= fmhp_pkg::InfoMinLen);
  assign next_idx = {1'b0, cnt_q} + 1'b1;
  assign hdr_len  = {len_q[LW-9:0], data_byte_i};

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    kind_d    = kind_q;
    fin_d     = fin_q;
    magic_d   = magic_q;
    p_rate_d  = p_rate_q;
    p_samp_d  = p_samp_q;
    p_chan_d  = p_chan_q;
    c_valid_d = c_valid_q;
    c_rate_d  = c_rate_q;
    c_samp_d  = c_samp_q;
    c_chan_d  = c_chan_q;
    if (cmd_i.take_byte) begin
      unique case (phase_q)
        fmhp_pkg::PH_MAGIC: begin
          if (data_byte_i != fmhp_pkg::magic_byte(cnt_q[1:0])) begin
            phase_d = fmhp_pkg::PH_IGNORE;
          end else if (cnt_q >= fmhp_pkg::MagicLastIdx) begin
            magic_d = 1'b1;
            cnt_d   = '0;
            phase_d = fmhp_pkg::PH_HEADER;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        fmhp_pkg::PH_HEADER: begin
          if (cnt_q == '0) begin
            kind_d = data_byte_i[KW-1:0];
            fin_d  = data_byte_i[7];
            len_d  = '0;
            cnt_d  = LW'(1);
          end else begin
            len_d = hdr_len;
            if (cnt_q >= fmhp_pkg::HeaderLastIdx) begin
              cnt_d = '0;
              if (hdr_len == '0) begin
                phase_d = fin_q ? fmhp_pkg::PH_IGNORE : fmhp_pkg::PH_HEADER;
              end else begin
                phase_d = fmhp_pkg::PH_BODY;
              end
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
        fmhp_pkg::PH_BODY: begin
          if (info) begin
            case (cnt_q)
              fmhp_pkg::OffRateHi:  p_rate_d[19:12] = data_byte_i;
              fmhp_pkg::OffRateMid: p_rate_d[11:4]  = data_byte_i;
              fmhp_pkg::OffRateLo: begin
                p_rate_d[3:0] = data_byte_i[7:4];
                p_chan_d      = data_byte_i[3:1];
              end
              fmhp_pkg::OffSampHi:  p_samp_d[35:32] = data_byte_i[3:0];
              fmhp_pkg::OffSamp3:   p_samp_d[31:24] = data_byte_i;
              fmhp_pkg::OffSamp2:   p_samp_d[23:16] = data_byte_i;
              fmhp_pkg::OffSamp1:   p_samp_d[15:8]  = data_byte_i;
              fmhp_pkg::OffSamp0:   p_samp_d[7:0]   = data_byte_i;
              default: ;
            endcase
          end
          if (next_idx >= {1'b0, len_q}) begin
            // body complete: commit stream info with this byte included
            if (info) begin
              c_valid_d = 1'b1;
              c_rate_d  = p_rate_d;
              c_samp_d  = p_samp_d;
              c_chan_d  = p_chan_d;
            end
            cnt_d   = '0;
            phase_d = fin_q ? fmhp_pkg::PH_IGNORE : fmhp_pkg::PH_HEADER;
          end else begin
            cnt_d = next_idx[LW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= fmhp_pkg::PH_MAGIC;
      cnt_q     <= '0;
      len_q     <= '0;
      kind_q    <= '0;
      fin_q     <= 1'b0;
      magic_q   <= 1'b0;
      p_rate_q  <= '0;
      p_samp_q  <= '0;
      p_chan_q  <= '0;
      c_valid_q <= 1'b0;
      c_rate_q  <= '0;
      c_samp_q  <= '0;
      c_chan_q  <= '0;
    end else if (cmd_i.take_byte && last_byte_i) begin
      phase_q   <= fmhp_pkg::PH_MAGIC;
      cnt_q     <= '0;
      len_q     <= '0;
      kind_q    <= '0;
      fin_q     <= 1'b0;
      magic_q   <= 1'b0;
      p_rate_q  <= '0;
      p_samp_q  <= '0;
      p_chan_q  <= '0;
      c_valid_q <= 1'b0;
      c_rate_q  <= '0;
      c_samp_q  <= '0;
      c_chan_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      kind_q    <= kind_d;
      fin_q     <= fin_d;
      magic_q   <= magic_d;
      p_rate_q  <= p_rate_d;
      p_samp_q  <= p_samp_d;
      p_chan_q  <= p_chan_d;
      c_valid_q <= c_valid_d;
      c_rate_q  <= c_rate_d;
      c_samp_q  <= c_samp_d;
      c_chan_q  <= c_chan_d;
    end
  end

  // restoring divider, one quotient bit per step
  assign shifted = {rem_q[RW-1:0], quo_q[SW-1]};
  assign diff    = shifted - {1'b0, s_rate_q};
  assign s_rz    = s_found_q && (s_rate_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      s_magic_q <= magic_d;
      s_found_q <= c_valid_d;
      s_chan_q  <= c_valid_d ? ({1'b0, c_chan_d} + 4'd1) : 4'd0;
      s_rate_q  <= c_valid_d ? c_rate_d : '0;
      s_samp_q  <= c_valid_d ? c_samp_d : '0;
      quo_q     <= c_valid_d ? c_samp_d : '0;
      rem_q     <= '0;
    end else if (cmd_i.div_step) begin
      if (!diff[RW]) begin
        rem_q <= diff;
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      is_flac_o       <= s_magic_q;
      info_found_o    <= s_found_q;
      channel_count_o <= s_chan_q;
      sample_rate_o   <= s_rate_q;
      total_samples_o <= s_samp_q;
      play_seconds_o  <= (s_found_q && !s_rz) ? quo_q : '0;
      rate_zero_o     <= s_rz;
    end
  end

  a_phase_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take_byte && last_byte_i) |=> (phase_q == fmhp_pkg::PH_MAGIC && !c_valid_q))
    else $error("parser not cleared after last byte");

  a_body_counter_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == fmhp_pkg::PH_BODY) |-> (cnt_q < len_q))
    else $error("body index ran past block length");

  a_commit_needs_magic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> magic_q)
    else $error("stream info committed without magic");

endmodule
`default_nettype wire

// ===== tb/flac_summary_checker.sv =====
module flac_summary_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fmhp_req_if       req_i,
  fmhp_res_if       res_i,
  output int        errors_o,
  output int        pending_o
);

  localparam logic [31:0] FlacTag = 32'h664C6143;

  typedef struct packed {
    logic        is_flac;
    logic        info_found;
    logic [3:0]  channel_count;
    logic [19:0] sample_rate;
    logic [35:0] total_samples;
    logic [35:0] play_seconds;
    logic        rate_zero;
  } summary_t;

  // parser state
  fmhp_pkg::phase_e parse_at;
  logic [23:0] pos;
  logic [23:0] blk_len;
  logic [6:0]  blk_kind;
  logic        blk_last;
  logic        magic_seen;

  // stream info being gathered, and the last complete one
  logic [19:0] gather_rate;
  logic [35:0] gather_samples;
  logic [2:0]  gather_chan;
  logic        held_valid;
  logic [19:0] held_rate;
  logic [35:0] held_samples;
  logic [2:0]  held_chan;

  summary_t due_summaries[$];
  int       mismatch_count = 0;

  assign errors_o = mismatch_count;

  task automatic report_mismatch(input string field, input logic [35:0] got,
                                 input logic [35:0] want);
    $display("%0t flac_summary_checker: %s got 'h%0h, want 'h%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic clear_parse();
    parse_at       = fmhp_pkg::PH_MAGIC;
    pos            = '0;
    blk_len        = '0;
    blk_kind       = '0;
    blk_last       = 1'b0;
    magic_seen     = 1'b0;
    gather_rate    = '0;
    gather_samples = '0;
    gather_chan    = '0;
    held_valid     = 1'b0;
    held_rate      = '0;
    held_samples   = '0;
    held_chan      = '0;
  endtask

  task automatic close_block();
    pos      = '0;
    parse_at = blk_last ? fmhp_pkg::PH_IGNORE : fmhp_pkg::PH_HEADER;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic info;
    case (parse_at)
      fmhp_pkg::PH_MAGIC: begin
        if (b != FlacTag[8*(3 - pos[1:0]) +: 8]) begin
          parse_at = fmhp_pkg::PH_IGNORE;
        end else if (pos >= 24'd3) begin
          magic_seen = 1'b1;
          pos        = '0;
          parse_at   = fmhp_pkg::PH_HEADER;
        end else begin
          pos = pos + 24'd1;
        end
      end
      fmhp_pkg::PH_HEADER: begin
        if (pos == '0) begin
          blk_kind = b[6:0];
          blk_last = b[7];
          blk_len  = '0;
          pos      = 24'd1;
        end else begin
          blk_len = {blk_len[15:0], b};
          if (pos >= 24'd3) begin
            pos = '0;
            if (blk_len == '0) close_block();
            else parse_at = fmhp_pkg::PH_BODY;
          end else begin
            pos = pos + 24'd1;
          end
        end
      end
      fmhp_pkg::PH_BODY: begin
        info = (blk_kind == fmhp_pkg::KindStreamInfo) && (blk_len >= fmhp_pkg::InfoMinLen);
        if (info) begin
          case (pos)
            fmhp_pkg::OffRateHi:  gather_rate[19:12] = b;
            fmhp_pkg::OffRateMid: gather_rate[11:4] = b;
            fmhp_pkg::OffRateLo: begin
              gather_rate[3:0] = b[7:4];
              gather_chan      = b[3:1];
            end
            fmhp_pkg::OffSampHi: gather_samples[35:32] = b[3:0];
            fmhp_pkg::OffSamp3:  gather_samples[31:24] = b;
            fmhp_pkg::OffSamp2:  gather_samples[23:16] = b;
            fmhp_pkg::OffSamp1:  gather_samples[15:8] = b;
            fmhp_pkg::OffSamp0:  gather_samples[7:0] = b;
            default: ;
          endcase
        end
        if ({1'b0, pos} + 25'd1 >= {1'b0, blk_len}) begin
          if (info) begin
            held_valid   = 1'b1;
            held_rate    = gather_rate;
            held_samples = gather_samples;
            held_chan    = gather_chan;
          end
          close_block();
        end else begin
          pos = pos + 24'd1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    summary_t want;
    if (!rst_ni) begin
      clear_parse();
      due_summaries.delete();
      pending_o <= 0;
    end else begin
      if (res_i.valid === 1'b1 && res_i.ready === 1'b1) begin
        if (due_summaries.size() == 0) begin
          report_mismatch("result with nothing due", '0, '0);
        end else begin
          want = due_summaries.pop_front();
          if (res_i.is_flac !== want.is_flac)
            report_mismatch("is_flac", res_i.is_flac, want.is_flac);
          if (res_i.info_found !== want.info_found)
            report_mismatch("info_found", res_i.info_found, want.info_found);
          if (res_i.channel_count !== want.channel_count)
            report_mismatch("channel_count", res_i.channel_count, want.channel_count);
          if (res_i.sample_rate !== want.sample_rate)
            report_mismatch("sample_rate", res_i.sample_rate, want.sample_rate);
          if (res_i.total_samples !== want.total_samples)
            report_mismatch("total_samples", res_i.total_samples, want.total_samples);
          if (res_i.play_seconds !== want.play_seconds)
            report_mismatch("play_seconds", res_i.play_seconds, want.play_seconds);
          if (res_i.rate_zero !== want.rate_zero)
            report_mismatch("rate_zero", res_i.rate_zero, want.rate_zero);
        end
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        parse_byte(req_i.data_byte);
        if (req_i.last_byte) begin
          // last byte of the buffer: summarize, then start over
          want         = '0;
          want.is_flac = magic_seen;
          if (held_valid) begin
            want.info_found    = 1'b1;
            want.channel_count = {1'b0, held_chan} + 4'd1;
            want.sample_rate   = held_rate;
            want.total_samples = held_samples;
            if (held_rate == '0) want.rate_zero = 1'b1;
            else want.play_seconds = held_samples / {16'd0, held_rate};
          end
          due_summaries.push_back(want);
          clear_parse();
        end
      end
      pending_o <= due_summaries.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam logic [31:0] FlacTag = 32'h664C6143;

  // receiver hold long enough that two buffers finish behind a waiting result
  localparam int LongHold     = 400;
  // cycles with no request and no result before the run is called hung
  localparam int StallLimit   = 2000;
  // settle time after the drain, covering the divider and the output stage
  localparam int SettleCycles = 64;
  localparam int TargetBytes  = 850;
  localparam int MinFiles     = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  fmhp_req_if byte_if ();
  fmhp_res_if sum_if ();

  int errors;
  int due_count;

  flac_metadata_header_parser_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (byte_if),
    .res_o  (sum_if)
  );

  flac_summary_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (byte_if),
    .res_i     (sum_if),
    .errors_o  (errors),
    .pending_o (due_count)
  );

  // bytes of the buffer under construction
  logic [7:0] file_bytes[$];

  int burst_left  = 0;
  int sent_bytes  = 0;
  int files_sent  = 0;
  // the stimulus asks for a long receiver hold by bumping this count
  int holds_asked = 0;
  int holds_done  = 0;

  task automatic add_magic();
    int k;
    for (k = 0; k < 4; k++) file_bytes.push_back(FlacTag[8*(3 - k) +: 8]);
  endtask

  // one block header: final flag and kind in the first byte, then big-endian length
  task automatic add_header(input logic fin, input logic [6:0] kind, input logic [23:0] len);
    file_bytes.push_back({fin, kind});
    file_bytes.push_back(len[23:16]);
    file_bytes.push_back(len[15:8]);
    file_bytes.push_back(len[7:0]);
  endtask

  task automatic add_noise(input int n);
    int k;
    for (k = 0; k < n; k++) file_bytes.push_back(8'($urandom));
  endtask

  // stream the buffer out one request per byte, in bursts with random gaps
  task automatic send_file();
    int n;
    int k;
    int gap;
    n = file_bytes.size();
    for (k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        // now and then a long burst so that stretches run without gaps
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          byte_if.valid     <= 1'b0;
          byte_if.data_byte <= 8'($urandom);
          byte_if.last_byte <= 1'($urandom);
          repeat (gap) @(posedge clk_i);
        end
      end
      byte_if.valid     <= 1'b1;
      byte_if.data_byte <= file_bytes[k];
      byte_if.last_byte <= (k == n - 1);
      do @(posedge clk_i); while (byte_if.ready !== 1'b1);
      burst_left--;
      sent_bytes++;
    end
    file_bytes.delete();
    files_sent++;
  endtask

  // stop offering until every summary has come back
  task automatic drain();
    byte_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (due_count != 0);
  endtask

  // sender side: directed buffers first, then random ones
  initial begin : stimulus
    int          nblk;
    int          len;
    int          cut;
    int          pick;
    int          j;
    int          k;
    logic        fin;
    logic [19:0] rate;
    logic [35:0] samples;
    logic [2:0]  chan;
    logic [7:0]  b;

    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= 8'h00;
    byte_if.last_byte <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single byte buffer, wrong first magic byte
    file_bytes.push_back(8'h00);
    send_file();
    // buffer ends inside a correct magic
    add_magic();
    void'(file_bytes.pop_back());
    send_file();
    // magic, then a header cut after two bytes
    add_magic();
    file_bytes.push_back(8'h80);
    file_bytes.push_back(8'h00);
    send_file();
    // last magic byte wrong, the byte after it is ignored
    add_magic();
    file_bytes[3] = 8'h42;
    file_bytes.push_back(8'hFF);
    send_file();
    // final block of the highest kind and largest length, cut right after its header
    add_magic();
    add_header(1'b1, 7'h7F, 24'hFFFFFF);
    send_file();

    while (sent_bytes < TargetBytes || files_sent < MinFiles) begin
      // once, the receiver goes quiet while buffers keep coming
      if (files_sent == 12) holds_asked++;
      if (files_sent % 15 == 14) drain();

      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // short buffer: a piece of the magic
        add_magic();
        cut = $urandom_range(1, 3);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end else if (pick == 1) begin
        // magic with one flipped bit, then some bytes that must be ignored
        add_magic();
        j = $urandom_range(0, 31);
        file_bytes[j / 8] = file_bytes[j / 8] ^ (8'd1 << (j % 8));
        add_noise($urandom_range(0, 6));
      end else if (pick == 2) begin
        add_noise($urandom_range(1, 12));
      end else begin
        // well formed buffer: magic and a few blocks with random content
        add_magic();
        nblk = $urandom_range(0, 4);
        for (j = 0; j < nblk; j++) begin
          // the last block mostly carries the final flag
          fin  = (j == nblk - 1) && ($urandom_range(0, 7) != 0);
          pick = $urandom_range(0, 19);
          if (pick < 10) begin
            // stream info, usually just long enough, sometimes full size
            len = ($urandom_range(0, 5) == 0) ? 34 : $urandom_range(18, 24);
            add_header(fin, fmhp_pkg::KindStreamInfo, 24'(len));
            pick = $urandom_range(0, 5);
            if (pick == 0) rate = '0;
            else if (pick == 1) rate = '1;
            else if (pick == 2) rate = 20'd1;
            else if (pick == 3) rate = 20'd44100;
            else rate = 20'($urandom);
            pick = $urandom_range(0, 4);
            if (pick == 0) samples = '0;
            else if (pick == 1) samples = '1;
            else if (pick == 2) samples = 36'($urandom_range(0, 100000));
            else samples = {4'($urandom), 32'($urandom)};
            chan = 3'($urandom);
            for (k = 0; k < len; k++) begin
              case (k)
                10: b = rate[19:12];
                11: b = rate[11:4];
                12: b = {rate[3:0], chan, 1'($urandom)};
                13: b = {4'($urandom), samples[35:32]};
                14: b = samples[31:24];
                15: b = samples[23:16];
                16: b = samples[15:8];
                17: b = samples[7:0];
                default: b = 8'($urandom);
              endcase
              file_bytes.push_back(b);
            end
          end else if (pick < 13) begin
            // stream info too short to count
            len = $urandom_range(0, 17);
            add_header(fin, fmhp_pkg::KindStreamInfo, 24'(len));
            add_noise(len);
          end else if (pick == 13) begin
            // huge block that the buffer end cuts short
            if ($urandom_range(0, 1) == 0) add_header(fin, 7'($urandom), 24'hFFFFFF);
            else add_header(fin, 7'($urandom), 24'($urandom_range(1000, 24'hFFFFFF)));
            add_noise($urandom_range(0, 5));
            j = nblk;
          end else begin
            // some other kind of block, possibly empty
            len = $urandom_range(0, 8);
            add_header(fin, 7'($urandom_range(1, 127)), 24'(len));
            add_noise(len);
          end
        end
        // trailing bytes, ignored when the last block carries the final flag
        if ($urandom_range(0, 2) == 0) add_noise($urandom_range(1, 4));
        // sometimes cut the buffer anywhere
        if ($urandom_range(0, 3) == 0) begin
          cut = $urandom_range(1, file_bytes.size());
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
      end
      send_file();
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0 && due_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // receiver side: stretches of steady, patchy and mostly stalled ready
  initial begin : sink_side
    int mode;
    int left;
    mode = 0;
    left = 0;
    sum_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_done) begin
        // long hold, counted here, while the sender keeps going
        sum_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        holds_done++;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(10, 60);
        end
        left--;
        case (mode)
          0:       sum_if.ready <= 1'b1;
          1:       sum_if.ready <= 1'($urandom_range(0, 1));
          default: sum_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // hang detection: too many cycles without a request or a result moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (sum_if.valid && sum_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
